/* hdl/buddy_bitmap_allocator_defines.svh */
// Assertion macros shared by the checker of the buddy bitmap allocator.
`ifndef BUDDY_BITMAP_ALLOCATOR_DEFINES_SVH
`define BUDDY_BITMAP_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the trigger.
`define BBA_ASSERT_NOW(lbl, trig, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error("allocator check failed");

// The consequent must hold in the cycle after the trigger.
`define BBA_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error("allocator check failed");

`endif

/* hdl/bba_pkg.sv */
`default_nettype none
package bba_pkg;

    localparam int LEVELS_DEF     = 10;
    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int RESET_COUNT    = 1024;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    typedef enum logic [2:0] {
        S_BUILD,
        S_CLEAR,
        S_IDLE,
        S_START,
        S_NEXT,
        S_RD,
        S_MOD,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_SCAN,
        PH_UP,
        PH_DOWN,
        PH_FUP,
        PH_FSIB,
        PH_FCHK
    } t_phase;

    typedef enum logic [1:0] {
        M_SET,
        M_CLR,
        M_SCAN,
        M_TEST
    } t_mode;

endpackage
`default_nettype wire

/* hdl/buddy_bitmap_allocator.sv */
// Operation: an allocate reads the level's bitmap words, up to ceil(level count/32)+1 of them,
//   for a clear bit, then sets that bit and one bit per ancestor level, then sets the descendant
//   range on each lower level word by word. A free clears the descendants the same way, then
//   clears bits upwards level by level and tests each sibling, stopping at a busy one.
// Throughput: one item at a time; the single-port bitmap memory read-modify-write sets the rate.
// Reset (synchronous, active low) and every count change rebuild the tables level by level,
//   then clear the bitmap one word per cycle; no beat is taken meanwhile.
`default_nettype none
module buddy_bitmap_allocator #(
    parameter int LEVELS     = bba_pkg::LEVELS_DEF,
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: block_count, written whenever the enable is high.
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_wdata,
    // Request stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // level[3:0], pos[13:4], zero fill
    input  wire logic [0:0]  s_axis_tuser,  // func[0]
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // status[1:0], pos_res[11:2], zero fill
);
    import bba_pkg::*;

    // Bitmap geometry: level L starts at bit offset[L] of a packed word array.
    localparam int BITS  = 2 * MAX_BLOCKS + LEVELS;
    localparam int WORDS = (BITS + 31) / 32;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(MAX_BLOCKS + 1);
    localparam int OW    = $clog2(BITS + 1);
    localparam int AW    = OW + 6;
    localparam int LW    = $clog2(LEVELS + 1);
    localparam int IW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    // A descendant range start stays below count plus span.
    localparam int BW    = $clog2(MAX_BLOCKS + 2 ** LEVELS) + 1;
    localparam int RSTN  = (RESET_COUNT > MAX_BLOCKS) ? MAX_BLOCKS : RESET_COUNT;

    // The bitmap memory, with a registered read port.
    logic [31:0]   r_mem [WORDS];
    logic [31:0]   r_rdata;
    logic          mem_re, mem_we;
    logic [WW-1:0] mem_addr;
    logic [31:0]   mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    // Per-level tables, rebuilt one level per cycle.
    logic [CW-1:0] r_cnt [LEVELS];
    logic [OW-1:0] r_off [LEVELS];

    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    t_mode         r_mode, n_mode;
    logic          r_func, n_func;
    logic [LW-1:0] r_lv, n_lv;
    logic [9:0]    r_pos, n_pos;
    logic [LW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [BW-1:0] r_base, n_base;
    logic [BW-1:0] r_span, n_span;
    logic [CW-1:0] r_p, n_p;
    logic [OW-1:0] r_lo, n_lo;
    logic [OW-1:0] r_hi, n_hi;
    logic [WW-1:0] r_w, n_w;
    logic [WW-1:0] r_we, n_we;
    logic          r_bit, n_bit;
    logic [1:0]    r_rstat, n_rstat;
    logic [9:0]    r_rpos, n_rpos;
    logic [1:0]    r_ostat, n_ostat;
    logic [9:0]    r_opos, n_opos;
    logic          r_ovalid, n_ovalid;
    logic [CW-1:0] r_bc, n_bc;
    logic [CW-1:0] r_bn, n_bn;
    logic [OW-1:0] r_bt, n_bt;
    logic [IW-1:0] r_bi, n_bi;
    logic          tbl_we;

    // Table lookup: the descendant walk looks one level below the current one.
    logic [LW-1:0] w_tidx;
    logic [IW-1:0] w_tsel;
    logic          w_tok;
    logic [CW-1:0] w_tcnt;
    logic [OW-1:0] w_toff;

    always_comb begin
        w_tidx = (r_phase == PH_DOWN) ? r_i - LW'(1) : r_i;
        w_tsel = w_tidx[IW-1:0];
        w_tok  = (32'(w_tidx) < LEVELS);
        w_tcnt = w_tok ? r_cnt[w_tsel] : '0;
        w_toff = w_tok ? r_off[w_tsel] : '0;
    end

    // Mask of the current word's bits that lie inside [r_lo, r_hi).
    logic [31:0]   w_mask;
    logic [AW-1:0] w_wbase;
    logic [AW-1:0] w_addr_k;
    logic [31:0]   w_zero;
    logic [4:0]    w_kf;
    logic [AW-1:0] w_abs;

    always_comb begin
        w_wbase = AW'(r_w) << 5;
        for (int k = 0; k < 32; k++) begin
            w_addr_k  = w_wbase + AW'(k);
            w_mask[k] = (w_addr_k >= AW'(r_lo)) && (w_addr_k < AW'(r_hi));
        end
        w_zero = ~r_rdata & w_mask;
        w_kf   = 5'd0;
        for (int k = 31; k >= 0; k--) begin
            if (w_zero[k]) begin
                w_kf = 5'(k);
            end
        end
        w_abs = w_wbase + AW'(w_kf);
    end

    // Effective count of a configuration write.
    logic [CW-1:0] w_eff;
    always_comb begin
        if (i_cfg_wdata == 11'd0) begin
            w_eff = CW'(1);
        end else if (32'(i_cfg_wdata) > MAX_BLOCKS) begin
            w_eff = CW'(MAX_BLOCKS);
        end else begin
            w_eff = CW'(i_cfg_wdata);
        end
    end

    logic [BW-1:0] w_nbase, w_nspan;
    logic [BW:0]   w_end;
    logic [CW-1:0] w_endrel;
    logic [CW-1:0] w_sib;
    logic [CW:0]   w_bnext;

    always_comb begin
        w_nbase  = r_base << 1;
        w_nspan  = r_span << 1;
        w_end    = (BW + 1)'(w_nbase) + (BW + 1)'(w_nspan);
        w_endrel = (w_end < (BW + 1)'(w_tcnt)) ? CW'(w_end) : w_tcnt;
        w_sib    = r_j ^ CW'(1);
        w_bnext  = ((CW + 1)'(r_bn) + (CW + 1)'(1)) >> 1;
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_mode   = r_mode;
        n_func   = r_func;
        n_lv     = r_lv;
        n_pos    = r_pos;
        n_i      = r_i;
        n_j      = r_j;
        n_base   = r_base;
        n_span   = r_span;
        n_p      = r_p;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_w      = r_w;
        n_we     = r_we;
        n_bit    = r_bit;
        n_rstat  = r_rstat;
        n_rpos   = r_rpos;
        n_ostat  = r_ostat;
        n_opos   = r_opos;
        n_ovalid = r_ovalid;
        n_bc     = r_bc;
        n_bn     = r_bn;
        n_bt     = r_bt;
        n_bi     = r_bi;
        tbl_we   = 1'b0;
        mem_re   = 1'b0;
        mem_we   = 1'b0;
        mem_addr = r_w;
        mem_wdata = '0;
        s_axis_tready = (r_state == S_IDLE);

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_BUILD: begin
                tbl_we = 1'b1;
                n_bt   = r_bt + OW'(r_bn);
                n_bn   = CW'(w_bnext);
                if (32'(r_bi) == LEVELS - 1) begin
                    n_w     = '0;
                    n_state = S_CLEAR;
                end else begin
                    n_bi = r_bi + IW'(1);
                end
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                if (32'(r_w) == WORDS - 1) begin
                    n_state = S_IDLE;
                end else begin
                    n_w = r_w + WW'(1);
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    // The table lookup must see the requested level itself.
                    n_phase = PH_SCAN;
                    n_func = s_axis_tuser[0];
                    n_pos  = s_axis_tdata[13:4];
                    n_lv   = LW'(s_axis_tdata[3:0]);
                    n_i    = LW'(s_axis_tdata[3:0]);
                    n_rpos = '0;
                    if (32'(s_axis_tdata[3:0]) >= LEVELS) begin
                        n_rstat = ST_BAD;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (r_func == FN_ALLOC) begin
                    n_phase = PH_SCAN;
                    n_mode  = M_SCAN;
                    n_lo    = w_toff;
                    n_hi    = w_toff + OW'(w_tcnt);
                    n_w     = WW'(w_toff >> 5);
                    n_we    = WW'((w_toff + OW'(w_tcnt) - OW'(1)) >> 5);
                    n_state = S_RD;
                end else if (32'(r_pos) >= 32'(w_tcnt)) begin
                    n_rstat = ST_BAD;
                    n_state = S_DONE;
                end else begin
                    n_phase = PH_DOWN;
                    n_base  = BW'(r_pos);
                    n_span  = BW'(1);
                    n_j     = CW'(r_pos);
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                unique case (r_phase)
                    PH_UP: begin
                        if (32'(r_i) == LEVELS) begin
                            n_phase = PH_DOWN;
                            n_i     = r_lv;
                            n_base  = BW'(r_p);
                            n_span  = BW'(1);
                        end else begin
                            n_mode  = M_SET;
                            n_lo    = w_toff + OW'(r_j);
                            n_hi    = w_toff + OW'(r_j) + OW'(1);
                            n_w     = WW'((w_toff + OW'(r_j)) >> 5);
                            n_we    = WW'((w_toff + OW'(r_j)) >> 5);
                            n_i     = r_i + LW'(1);
                            n_j     = r_j >> 1;
                            n_state = S_RD;
                        end
                    end
                    PH_DOWN: begin
                        if (r_i == '0) begin
                            if (r_func == FN_ALLOC) begin
                                n_rstat = ST_DONE;
                                n_rpos  = 10'(r_p);
                                n_state = S_DONE;
                            end else begin
                                n_phase = PH_FUP;
                                n_i     = r_lv;
                                n_j     = CW'(r_pos);
                            end
                        end else begin
                            n_i    = r_i - LW'(1);
                            n_base = w_nbase;
                            n_span = w_nspan;
                            // A range wholly past the level's end is skipped.
                            if ((BW + 1)'(w_nbase) < (BW + 1)'(w_tcnt)) begin
                                n_mode  = (r_func == FN_ALLOC) ? M_SET : M_CLR;
                                n_lo    = w_toff + OW'(w_nbase);
                                n_hi    = w_toff + OW'(w_endrel);
                                n_w     = WW'((w_toff + OW'(w_nbase)) >> 5);
                                n_we    = WW'((w_toff + OW'(w_endrel) - OW'(1)) >> 5);
                                n_state = S_RD;
                            end
                        end
                    end
                    PH_FUP: begin
                        if (32'(r_i) == LEVELS) begin
                            n_rstat = ST_DONE;
                            n_state = S_DONE;
                        end else begin
                            n_mode  = M_CLR;
                            n_lo    = w_toff + OW'(r_j);
                            n_hi    = w_toff + OW'(r_j) + OW'(1);
                            n_w     = WW'((w_toff + OW'(r_j)) >> 5);
                            n_we    = WW'((w_toff + OW'(r_j)) >> 5);
                            n_phase = PH_FSIB;
                            n_state = S_RD;
                        end
                    end
                    PH_FSIB: begin
                        if (w_sib < w_tcnt) begin
                            n_mode  = M_TEST;
                            n_lo    = w_toff + OW'(w_sib);
                            n_hi    = w_toff + OW'(w_sib) + OW'(1);
                            n_w     = WW'((w_toff + OW'(w_sib)) >> 5);
                            n_we    = WW'((w_toff + OW'(w_sib)) >> 5);
                            n_phase = PH_FCHK;
                            n_state = S_RD;
                        end else begin
                            n_i     = r_i + LW'(1);
                            n_j     = r_j >> 1;
                            n_phase = PH_FUP;
                        end
                    end
                    PH_FCHK: begin
                        // A busy sibling keeps the parent busy, so the walk ends.
                        if (r_bit) begin
                            n_rstat = ST_DONE;
                            n_state = S_DONE;
                        end else begin
                            n_i     = r_i + LW'(1);
                            n_j     = r_j >> 1;
                            n_phase = PH_FUP;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RD: begin
                mem_re  = 1'b1;
                n_state = S_MOD;
            end
            S_MOD: begin
                unique case (r_mode)
                    M_SET, M_CLR: begin
                        mem_we    = 1'b1;
                        mem_wdata = (r_mode == M_SET) ? (r_rdata | w_mask)
                                                      : (r_rdata & ~w_mask);
                        if (r_w == r_we) begin
                            n_state = S_NEXT;
                        end else begin
                            n_w     = r_w + WW'(1);
                            n_state = S_RD;
                        end
                    end
                    M_TEST: begin
                        n_bit   = |(r_rdata & w_mask);
                        n_state = S_NEXT;
                    end
                    M_SCAN: begin
                        if (w_zero != '0) begin
                            n_p     = CW'(w_abs - AW'(w_toff));
                            n_j     = CW'(w_abs - AW'(w_toff));
                            n_phase = PH_UP;
                            n_state = S_NEXT;
                        end else if (r_w == r_we) begin
                            n_rstat = ST_NOFREE;
                            n_state = S_DONE;
                        end else begin
                            n_w     = r_w + WW'(1);
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        n_state = S_NEXT;
                    end
                endcase
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_rstat;
                    n_opos   = r_rpos;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A count change restarts the table build and the clearing pass.
        if (i_cfg_we && (w_eff != r_bc)) begin
            n_bc    = w_eff;
            n_bn    = w_eff;
            n_bt    = '0;
            n_bi    = '0;
            n_state = S_BUILD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_BUILD;
            r_ovalid <= 1'b0;
            r_bc     <= CW'(RSTN);
            r_bn     <= CW'(RSTN);
            r_bt     <= '0;
            r_bi     <= '0;
            r_phase  <= PH_SCAN;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_bc     <= n_bc;
            r_bn     <= n_bn;
            r_bt     <= n_bt;
            r_bi     <= n_bi;
            r_phase  <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_func  <= n_func;
        r_lv    <= n_lv;
        r_pos   <= n_pos;
        r_i     <= n_i;
        r_j     <= n_j;
        r_base  <= n_base;
        r_span  <= n_span;
        r_p     <= n_p;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_w     <= n_w;
        r_we    <= n_we;
        r_bit   <= n_bit;
        r_rstat <= n_rstat;
        r_rpos  <= n_rpos;
        r_ostat <= n_ostat;
        r_opos  <= n_opos;
        if (tbl_we) begin
            r_cnt[r_bi] <= r_bn;
            r_off[r_bi] <= r_bt;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0000, r_opos, r_ostat};

endmodule
`default_nettype wire

/* hdl/bba_checker.sv */
`default_nettype none
`include "buddy_bitmap_allocator_defines.svh"
module bba_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);
    import bba_pkg::*;

    // A stalled result beat holds.
    `BBA_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // Only one item is in work: no beat is taken right after one.
    `BBA_ASSERT_NEXT(a_one, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // The status is one of the three defined codes.
    `BBA_ASSERT_NOW(a_code, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
    // A failed request returns index zero.
    `BBA_ASSERT_NOW(a_zero, m_axis_tvalid && (m_axis_tdata[1:0] != ST_DONE), m_axis_tdata[11:2] == 10'd0)

endmodule

bind buddy_bitmap_allocator bba_checker u_bba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
